/* sv/wbss_pkg.sv */
`timescale 1ns / 1ps
package wbss_pkg;

  typedef logic [7:0] byte_t;

  localparam int DEF_MAX_PATTERN = 16;
  localparam int DEF_OFFSET_BITS = 32;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int PLEN_W = 5;
  localparam int DOFF_W = 4;
  localparam int ILEN_W = 4;
  localparam int MASK_W = 16;
  localparam int ADDR_W = 64;
  localparam int MOFF_W = 32;
  localparam int DISP_W = 32;
  localparam int DISP_BYTES = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_CARE_MASK    = 3'd2,
    REG_PATTERN_LEN  = 3'd3,
    REG_DISP_OFFSET  = 3'd4,
    REG_INSTR_LEN    = 3'd5,
    REG_BASE_ADDR    = 3'd6
  } reg_index_t;

  localparam logic [PLEN_W-1:0] RST_PATTERN_LEN = 5'd1;
  localparam logic [DOFF_W-1:0] RST_DISP_OFFSET = 4'd3;
  localparam logic [ILEN_W-1:0] RST_INSTR_LEN = 4'd7;

endpackage

/* sv/wbss_cell.sv */
`timescale 1ns / 1ps
module wbss_cell
  import wbss_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  logic  clear,
  input  byte_t byte_in,
  input  logic  match_in,
  input  byte_t new_byte,
  input  byte_t pattern_byte,
  input  logic  care,
  output byte_t byte_q,
  output logic  match_q,
  output logic  match_next
);

  // partial match through this pattern position, given the newest byte
  assign match_next = match_in && (!care || (new_byte == pattern_byte));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      match_q <= 1'b0;
    end else if (shift) begin
      match_q <= match_next;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      byte_q <= byte_in;
    end
  end

endmodule

/* sv/wbss_resolve.sv */
`timescale 1ns / 1ps
module wbss_resolve
  import wbss_pkg::*;
#(
  parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic                   item_found,
  input  logic [OFFSET_BITS-1:0] item_moff,
  input  logic [DISP_W-1:0]      item_disp,
  input  logic [ADDR_W-1:0]      base_address,
  input  logic [ILEN_W-1:0]      instruction_length,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   found,
  output logic [MOFF_W-1:0]      match_offset,
  output logic [ADDR_W-1:0]      resolved_address
);

  logic                   s1_valid;
  logic                   s1_found;
  logic [OFFSET_BITS-1:0] s1_moff;
  logic [DISP_W-1:0]      s1_disp;
  logic                   s2_valid;
  logic                   s2_found;
  logic [ADDR_W-1:0]      s2_moff;
  logic [ADDR_W-1:0]      s2_part;
  logic [ADDR_W-1:0]      s2_base;
  logic                   adv1;
  logic                   adv2;
  logic                   adv3;
  logic [ADDR_W-1:0]      moff_ext;

  assign adv3 = !out_valid || out_ready;
  assign adv2 = !s2_valid || adv3;
  assign adv1 = !s1_valid || adv2;
  assign item_ready = adv1;
  assign moff_ext = ADDR_W'(s1_moff);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid <= item_valid;
      if (adv2) s2_valid <= s1_valid;
      if (adv3) out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_found <= item_found;
      s1_moff <= item_moff;
      s1_disp <= item_disp;
    end
    if (adv2) begin
      s2_found <= s1_found;
      s2_moff <= moff_ext;
      s2_part <= moff_ext + {{(ADDR_W-DISP_W){s1_disp[DISP_W-1]}}, s1_disp};
      s2_base <= base_address + ADDR_W'(instruction_length);
    end
    if (adv3) begin
      found <= s2_found;
      match_offset <= s2_found ? s2_moff[MOFF_W-1:0] : '0;
      resolved_address <= s2_found ? (s2_part + s2_base) : '0;
    end
  end

endmodule

/* sv/wildcard_byte_signature_scanner.sv */
`timescale 1ns / 1ps
// Wildcard byte signature scanner.
// Input channel (in_valid/in_ready) carries one buffer byte per transaction;
// end_of_buffer marks the last byte. The pattern, care mask, length,
// displacement offset, instruction length and base address are set through
// the write port (cfg_write_enable/cfg_index/cfg_data) while the block is idle.
// Output channel (out_valid/out_ready) carries at most one result per buffer:
// the first match (found=1, offset, resolved address) or, if the buffer ends
// unmatched, found=0 with zero fields. Bytes after a match are dropped until
// end_of_buffer.
// Throughput: one byte per cycle while the result path is not stalled. A row of MAX_PATTERN cells shifts the byte
// window and carries partial-match flags, so every byte is compared in the
// cycle it is accepted.
// The accepted item passes through registers s1, s2 and the output register
// (displacement select, offset/displacement add, final address add).
// Reset clears the match chain, offset counter, match flag and result
// pipeline, and loads the register reset values. When the receiver stalls,
// the three result stages fill and then in_ready drops.
module wildcard_byte_signature_scanner
  import wbss_pkg::*;
#(
  parameter int MAX_PATTERN = DEF_MAX_PATTERN,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_enable,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_buffer,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   found,
  output logic [MOFF_W-1:0]      match_offset,
  output logic [ADDR_W-1:0]      resolved_address
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = $clog2(MAX_PATTERN);
  localparam int POS_W = 6;

  // configuration registers
  logic [63:0]       pattern_low_bytes;
  logic [63:0]       pattern_high_bytes;
  logic [MASK_W-1:0] care_mask;
  logic [PLEN_W-1:0] pattern_length;
  logic [DOFF_W-1:0] displacement_offset;
  logic [ILEN_W-1:0] instruction_length;
  logic [ADDR_W-1:0] base_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low_bytes <= '0;
      pattern_high_bytes <= '0;
      care_mask <= '0;
      pattern_length <= RST_PATTERN_LEN;
      displacement_offset <= RST_DISP_OFFSET;
      instruction_length <= RST_INSTR_LEN;
      base_address <= '0;
    end else if (cfg_write_enable) begin
      case (reg_index_t'(cfg_index))
        REG_PATTERN_LOW:  pattern_low_bytes <= cfg_data;
        REG_PATTERN_HIGH: pattern_high_bytes <= cfg_data;
        REG_CARE_MASK:    care_mask <= cfg_data[MASK_W-1:0];
        REG_PATTERN_LEN:  pattern_length <= cfg_data[PLEN_W-1:0];
        REG_DISP_OFFSET:  displacement_offset <= cfg_data[DOFF_W-1:0];
        REG_INSTR_LEN:    instruction_length <= cfg_data[ILEN_W-1:0];
        REG_BASE_ADDR:    base_address <= cfg_data;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // scan control
  logic                   accept;
  logic                   shift;
  logic                   clear;
  logic                   match_done;
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [127:0]           pattern_all;
  logic [LEN_W-1:0]       eff_len;
  logic [IDX_W-1:0]       hit_idx;
  logic                   hit;
  logic                   item_valid;
  logic                   item_ready;
  logic [OFFSET_BITS-1:0] item_moff;
  logic [DISP_W-1:0]      item_disp;

  byte_t cell_byte [MAX_PATTERN];
  byte_t win_new [MAX_PATTERN];   // window after this byte, index = age
  logic  cell_match [MAX_PATTERN];
  logic  match_next [MAX_PATTERN];

  assign in_ready = item_ready;
  assign accept = in_valid && in_ready;
  assign shift = accept && !match_done;
  assign clear = accept && end_of_buffer;
  assign pattern_all = {pattern_high_bytes, pattern_low_bytes};

  // length 0 acts as 1, anything above the cell count as the cell count
  always_comb begin
    if (pattern_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (pattern_length > PLEN_W'(MAX_PATTERN)) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = pattern_length[LEN_W-1:0];
    end
  end

  assign hit_idx = IDX_W'(eff_len - LEN_W'(1));

  // cell k holds the byte of age k and the flag "pattern bytes 0..k match
  // the k+1 most recent bytes"; the newest byte is broadcast to all cells
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign win_new[k] = data_byte;
    end else begin : g_body
      assign win_new[k] = cell_byte[k-1];
    end

    wbss_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .shift        (shift),
      .clear        (clear),
      .byte_in      (win_new[k]),
      .match_in     ((k == 0) ? 1'b1 : cell_match[(k == 0) ? 0 : k-1]),
      .new_byte     (data_byte),
      .pattern_byte (pattern_all[k*8 +: 8]),
      .care         (care_mask[k]),
      .byte_q       (cell_byte[k]),
      .match_q      (cell_match[k]),
      .match_next   (match_next[k])
    );
  end

  assign hit = match_next[hit_idx];

  // displacement bytes: match position p sits at age eff_len-1-p;
  // positions at or beyond the effective length read as zero
  always_comb begin
    logic [POS_W-1:0] pos;
    logic [IDX_W-1:0] age;
    item_disp = '0;
    for (int i = 0; i < DISP_BYTES; i++) begin
      pos = POS_W'(displacement_offset) + POS_W'(i);
      age = IDX_W'(POS_W'(eff_len) - POS_W'(1) - pos);
      if (pos < POS_W'(eff_len)) begin
        item_disp[i*8 +: 8] = win_new[age];
      end
    end
  end

  assign item_moff = bytes_seen + OFFSET_BITS'(1) - OFFSET_BITS'(eff_len);
  assign item_valid = shift && (hit || end_of_buffer);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      bytes_seen <= '0;
      match_done <= 1'b0;
    end else if (shift) begin
      bytes_seen <= bytes_seen + OFFSET_BITS'(1);
      if (hit) match_done <= 1'b1;
    end
  end

  wbss_resolve #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_resolve (
    .clk                (clk),
    .rst                (rst),
    .item_valid         (item_valid),
    .item_ready         (item_ready),
    .item_found         (hit),
    .item_moff          (item_moff),
    .item_disp          (item_disp),
    .base_address       (base_address),
    .instruction_length (instruction_length),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .found              (found),
    .match_offset       (match_offset),
    .resolved_address   (resolved_address)
  );

endmodule
